// ===== hdl/chrl_pkg.sv =====
// Shared widths, request codes and controller/datapath handshake types for the ring lookup.
`timescale 1ns / 1ps

package chrl_pkg;

  localparam int unsigned POINT_W = 32;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CFG_W   = 13;

  // request codes carried in req_type
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr;        // store the accepted entry
    logic start;     // latch key hash and search bounds
    logic addr;      // form mid, issue table reads
    logic cmp;       // compare read points, move bounds
    logic capture;   // latch the chosen owner id
    logic load_out;  // move captured result to the output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mid_ge_n;  // mid has run off the active entries
    logic hit;       // point[mid-1] < hash <= point[mid]
    logic stop;      // bounds crossed, answer is entry 0
  } dp_sts_t;

endpackage

// ===== hdl/chrl_if.sv =====
// Valid/ready channel interfaces for ring requests and lookup results.
`timescale 1ns / 1ps

interface chrl_req_if
  import chrl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [IDX_W-1:0]   entry_index;
  logic [POINT_W-1:0] entry_point;
  logic [ID_W-1:0]    entry_server_id;
  logic [POINT_W-1:0] key_hash;

  modport source (
    output valid, req_type, entry_index, entry_point, entry_server_id, key_hash,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_point, entry_server_id, key_hash,
    output ready
  );
endinterface

interface chrl_rsp_if
  import chrl_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] server_index;

  modport source (
    output valid, server_index,
    input  ready
  );
  modport sink (
    input  valid, server_index,
    output ready
  );
endinterface

// ===== hdl/chrl_ctrl.sv =====
// Sequencer for the ring lookup: request acceptance, search steps and result hand-off.
`timescale 1ns / 1ps

module chrl_ctrl
  import chrl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_req_type,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.wr       = accept & (in_req_type == REQ_WRITE);
    cmd.start    = accept & (in_req_type == REQ_LOOKUP);
    cmd.addr     = (state_r == S_ADDR);
    cmd.cmp      = (state_r == S_CMP);
    cmd.capture  = ((state_r == S_ADDR) & sts.mid_ge_n) |
                   ((state_r == S_CMP) & (sts.hit | sts.stop));
    cmd.load_out = (state_r == S_DONE) & out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) state_nxt = S_ADDR;
      end
      S_ADDR: begin
        state_nxt = sts.mid_ge_n ? S_DONE : S_CMP;
      end
      S_CMP: begin
        state_nxt = (sts.hit | sts.stop) ? S_DONE : S_ADDR;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/chrl_dp.sv =====
// Ring table memory, search bounds, point comparators and result registers.
`timescale 1ns / 1ps

module chrl_dp
  import chrl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic [POINT_W-1:0] entry_point,
  input  logic [ID_W-1:0]    entry_server_id,
  input  logic [POINT_W-1:0] key_hash,
  input  ctrl_cmd_t          cmd,
  output dp_sts_t            sts,
  output logic [ID_W-1:0]    server_index
);

  localparam int unsigned AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW      = AW + 1;
  localparam int unsigned ENTRY_W = ID_W + POINT_W;

  // entry word: owner id above point
  logic [ENTRY_W-1:0] ring_mem [TABLE_DEPTH];

  logic [CFG_W-1:0]   active_r;
  logic [CW-1:0]      lo_r, hi_r, n_r, mid_r;
  logic [POINT_W-1:0] hash_r;
  logic [ENTRY_W-1:0] rd_a_r, rd_b_r;
  logic [ID_W-1:0]    owner0_r;
  logic [ID_W-1:0]    res_r;
  logic [ID_W-1:0]    out_data_r;

  logic [31:0]        idx_ext;
  logic               idx_ok;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        act_ext;
  logic [31:0]        n_sat_w;
  logic [CW:0]        bound_sum;
  logic [CW-1:0]      mid_c, mid_dec_c;
  logic [CW-1:0]      mid_inc, mid_dec;
  logic [POINT_W-1:0] p, q;
  logic               go_up;
  logic [ID_W-1:0]    owner_sel;

  assign idx_ext = 32'(entry_index);
  assign idx_ok  = (idx_ext < 32'(TABLE_DEPTH));
  assign wr_addr = idx_ext[AW-1:0];

  // active count saturates at the table depth
  assign act_ext = 32'(active_r);
  assign n_sat_w = (act_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : act_ext;

  assign bound_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c     = bound_sum[CW:1];
  assign mid_dec_c = mid_c - CW'(1);

  assign mid_inc = mid_r + CW'(1);
  assign mid_dec = mid_r - CW'(1);

  assign p     = rd_a_r[POINT_W-1:0];
  assign q     = (mid_r == '0) ? '0 : rd_b_r[POINT_W-1:0];
  assign go_up = (p < hash_r);

  always_comb begin
    sts          = '0;
    sts.mid_ge_n = (mid_c >= n_r);
    sts.hit      = (hash_r <= p) && (hash_r > q);
    if (go_up) begin
      sts.stop = ~sts.hit & (mid_inc > hi_r);
    end else begin
      // moving below entry 0 also ends the search
      sts.stop = ~sts.hit & ((mid_r == '0) | (mid_dec < lo_r));
    end
  end

  assign owner_sel = (cmd.cmp & sts.hit) ? rd_a_r[ENTRY_W-1:POINT_W] : owner0_r;

  always_ff @(posedge clk) begin
    if (cmd.wr && idx_ok) begin
      ring_mem[wr_addr] <= {entry_server_id, entry_point};
    end
    rd_a_r <= ring_mem[mid_c[AW-1:0]];
    rd_b_r <= ring_mem[mid_dec_c[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CFG_W'(1);
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && (idx_ext == 32'd0)) begin
      owner0_r <= entry_server_id;
    end
    if (cmd.start) begin
      lo_r   <= '0;
      hi_r   <= n_sat_w[CW-1:0];
      n_r    <= n_sat_w[CW-1:0];
      hash_r <= key_hash;
    end else if (cmd.cmp) begin
      if (go_up) begin
        lo_r <= mid_inc;
      end else begin
        hi_r <= mid_dec;
      end
    end
    if (cmd.addr) begin
      mid_r <= mid_c;
    end
    if (cmd.capture) begin
      res_r <= owner_sel - ID_W'(1);
    end
    if (cmd.load_out) begin
      out_data_r <= res_r;
    end
  end

  assign server_index = out_data_r;

endmodule

// ===== hdl/consistent_hash_ring_lookup.sv =====
// Consistent-hash ring lookup: top level joining the sequencer and the datapath.
//
// in_req carries transactions of two kinds. A write (req_type 0) stores
// entry_point and entry_server_id at entry_index; it is absorbed in the cycle
// it is taken and gives no result, so writes can follow one per cycle while no
// lookup is in flight. A lookup (req_type 1) binary-searches the first
// active_entries points for the first point at or above key_hash, wrapping to
// entry 0, and returns that entry's id minus one on out_rsp. Each search step
// is a registered read of point[mid] and point[mid-1] on the dual read port and
// then the compare; a step whose mid runs past the active entries ends after its
// read. There are at most floor(log2(active_entries + 1)) + 1 steps (13 for
// 4096 entries). out_rsp.valid and in_req.ready rise in the same cycle, so a new
// lookup is taken only after the last one is through. in_req.ready is high only
// while no lookup is in flight. A finished result sits in the output register,
// and further transactions are taken while it waits; a lookup completing behind
// a stalled out_rsp holds its answer and the input until the register frees up.
// cfg_we/cfg_wdata set active_entries; write it only while idle.
// Reset (rst_n, synchronous) empties the output and sets active_entries to 1;
// table contents are undefined until written.
`timescale 1ns / 1ps

module consistent_hash_ring_lookup
  import chrl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  chrl_req_if.sink          in_req,
  chrl_rsp_if.source        out_rsp,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  chrl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .in_ready    (in_req.ready),
    .out_ready   (out_rsp.ready),
    .out_valid   (out_rsp.valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  chrl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .entry_index     (in_req.entry_index),
    .entry_point     (in_req.entry_point),
    .entry_server_id (in_req.entry_server_id),
    .key_hash        (in_req.key_hash),
    .cmd             (cmd),
    .sts             (sts),
    .server_index    (out_rsp.server_index)
  );

endmodule

// ===== tb/ring_lookup_checker.sv =====
// Ring lookup checker: mirrors the table, predicts each lookup's server and compares results.
`timescale 1ns / 1ps

module ring_lookup_checker
  import chrl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  chrl_req_if              req,
  chrl_rsp_if              rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending
);

  localparam int RING_DEPTH = 4096;

  bit [POINT_W-1:0] ring_pt    [RING_DEPTH];
  bit [ID_W-1:0]    ring_owner [RING_DEPTH];
  bit [CFG_W-1:0]   active_cnt = 1;
  bit [ID_W-1:0]    server_due_q[$];
  int               err_cnt = 0;

  initial begin
    mismatches <= 0;
    pending    <= 0;
  end

  // binary search for the first point at or above the hash, wrapping to entry 0
  function automatic bit [ID_W-1:0] pick_server(input bit [POINT_W-1:0] hash);
    int               n;
    int               lo;
    int               hi;
    int               mid;
    int               pick;
    bit               done;
    bit [POINT_W-1:0] p;
    bit [POINT_W-1:0] q;
    n = int'(active_cnt);
    if (n > RING_DEPTH) n = RING_DEPTH;
    lo   = 0;
    hi   = n;
    pick = 0;
    done = 0;
    while (!done) begin
      mid = (lo + hi) / 2;
      if (mid >= n) begin
        done = 1;
      end else begin
        p = ring_pt[mid];
        q = (mid == 0) ? '0 : ring_pt[mid-1];
        if (hash <= p && hash > q) begin
          pick = mid;
          done = 1;
        end else begin
          if (p < hash) lo = mid + 1;
          else          hi = mid - 1;
          if (lo > hi) done = 1;
        end
      end
    end
    return ring_owner[pick] - 16'd1;
  endfunction

  always @(posedge clk) begin
    bit [ID_W-1:0] want;
    if (!rst_n) begin
      active_cnt = 1;
      server_due_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (server_due_q.size() == 0) begin
          $error("server_index: expected no transaction, got %0d", rsp.server_index);
          err_cnt++;
        end else begin
          want = server_due_q.pop_front();
          if (rsp.server_index !== want) begin
            $error("server_index mismatch: expected %0d, got %0d", want, rsp.server_index);
            err_cnt++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_WRITE) begin
          ring_pt[req.entry_index]    = req.entry_point;
          ring_owner[req.entry_index] = req.entry_server_id;
        end else begin
          server_due_q.push_back(pick_server(req.key_hash));
        end
      end
      if (cfg_we) active_cnt = cfg_wdata;
    end
    pending    <= server_due_q.size();
    mismatches <= err_cnt;
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, ring table and lookup stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import chrl_pkg::*;

  localparam int RING_DEPTH   = 4096;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending;
  bit               hold_ask = 0;
  int               burst_left = 0;
  bit [POINT_W-1:0] pt_shadow [RING_DEPTH];

  chrl_req_if req_ch ();
  chrl_rsp_if rsp_ch ();

  consistent_hash_ring_lookup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ring_lookup_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // receiver: runs of always-ready, coin-flip and mostly-stalled, plus one long hold
  initial begin
    int mode;
    int left;
    bit hold_done;
    rsp_ch.ready = 0;
    mode      = 0;
    left      = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_ask && !hold_done) begin
        hold_done    = 1;
        rsp_ch.ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 150);
      end
      left--;
      case (mode)
        0:       rsp_ch.ready = 1'b1;
        1:       rsp_ch.ready = 1'($urandom_range(0, 1));
        default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic offer(input logic kind, input bit [IDX_W-1:0] idx,
                       input bit [POINT_W-1:0] pt, input bit [ID_W-1:0] id,
                       input bit [POINT_W-1:0] hash);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid           = 1'b1;
    req_ch.req_type        = kind;
    req_ch.entry_index     = idx;
    req_ch.entry_point     = pt;
    req_ch.entry_server_id = id;
    req_ch.key_hash        = hash;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic put_entry(input bit [IDX_W-1:0] idx, input bit [POINT_W-1:0] pt,
                           input bit [ID_W-1:0] id);
    pt_shadow[idx] = pt;
    offer(REQ_WRITE, idx, pt, id, $urandom);
  endtask

  task automatic ask(input bit [POINT_W-1:0] hash);
    offer(REQ_LOOKUP, IDX_W'($urandom_range(0, RING_DEPTH - 1)), $urandom,
          ID_W'($urandom_range(0, 65535)), hash);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  // drain every outstanding lookup before touching the register
  task automatic settle();
    go_quiet();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_active(input bit [CFG_W-1:0] n);
    settle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = n;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    int                ph;
    int                n;
    int                span;
    int                i;
    int                k;
    int                j;
    int                roll;
    longint unsigned   step;
    bit [POINT_W-1:0]  pt;
    bit [POINT_W-1:0]  hash;

    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_WRITE;
    req_ch.entry_index     = '0;
    req_ch.entry_point     = '0;
    req_ch.entry_server_id = '0;
    req_ch.key_hash        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // one entry at the reset size: below, on, above and at the top of the ring
    put_entry(0, 32'd1000, 16'd1);
    ask(32'd0);
    ask(32'd1000);
    ask(32'd1001);
    ask(32'hFFFF_FFFF);

    // zero entries acts as one
    set_active(0);
    ask(32'd5000);

    // small sorted ring with a zero id, a duplicate point and the top value
    put_entry(1, 32'd2000, 16'd0);
    put_entry(2, 32'd3000, 16'hFFFF);
    put_entry(3, 32'd3000, 16'd3);
    put_entry(4, 32'h8000_0000, 16'd4);
    put_entry(5, 32'hFFFF_0000, 16'd5);
    put_entry(6, 32'hFFFF_FFFE, 16'd6);
    put_entry(7, 32'hFFFF_FFFF, 16'hFFFF);
    set_active(8);
    ask(32'd0);
    ask(32'd1500);
    ask(32'd2000);
    ask(32'd3000);
    ask(32'h8000_0001);
    ask(32'hFFFF_FFFF);

    // break the ordering
    put_entry(4, 32'd10, 16'd7);
    ask(32'h7000_0000);
    ask(32'd5);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       n = 2;
        1:       n = 1;
        2:       n = 0;
        default: n = $urandom_range(3, 60);
      endcase
      if (n >= 1 && n <= RING_DEPTH) begin
        step = (64'd1 << 32) / n;
        for (i = 0; i < n; i++) begin
          pt = POINT_W'(i * step + $urandom_range(0, 32'(step - 1)));
          if (i > 0 && $urandom_range(0, 15) == 0) pt = pt_shadow[i-1];
          put_entry(IDX_W'(i), pt, ID_W'($urandom_range(1, 65535)));
        end
      end
      set_active(CFG_W'(n));
      span = (n == 0) ? 1 : ((n > RING_DEPTH) ? RING_DEPTH : n);
      for (k = 0; k < 25; k++) begin
        if (ph == 4 && k == 5) hold_ask = 1;
        roll = $urandom_range(0, 19);
        if (roll == 0 && span < RING_DEPTH) begin
          // beyond the active range: stored but never searched
          put_entry(IDX_W'($urandom_range(span, RING_DEPTH - 1)), $urandom,
                    ID_W'($urandom_range(1, 65535)));
        end else if (roll == 1) begin
          put_entry(IDX_W'($urandom_range(0, span - 1)), $urandom,
                    ID_W'($urandom_range(1, 65535)));
        end else begin
          case ($urandom_range(0, 9))
            0:       hash = '0;
            1:       hash = '1;
            2, 3:    hash = $urandom;
            default: begin
              j    = $urandom_range(0, span - 1);
              hash = pt_shadow[j] + 32'($urandom_range(0, 2)) - 32'd1;
            end
          endcase
          ask(hash);
        end
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
